// ===== rtl/core/bics_pkg.sv =====
// Package for the bucketed inverse-CDF sampler.
// Holds field widths, action and result codes, register indexes and the FSM type.
// No dependencies.
package bics_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 1024;

  localparam int IDX_W  = 10;
  localparam int VAL_W  = 33;
  localparam int UNI_W  = 32;
  localparam int SMP_W  = 32;
  localparam int BW_W   = 31;
  localparam int BIU_W  = 11;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [VAL_W-1:0] ONE_Q32 = {1'b1, 32'd0};

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_QUERY  = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    REG_RANGE_MIN      = 2'd0,
    REG_BUCKET_WIDTH   = 2'd1,
    REG_BUCKETS_IN_USE = 2'd2,
    REG_NONE           = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_QRD,
    ST_QPRV,
    ST_QDIF,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/core/bucketed_inverse_cdf_sampler_unit.sv =====
// Top level of the bucketed inverse-CDF sampler: CDF table memory, scan FSM,
// scaling and output register. Depends on bics_pkg.
//
// Usage:
//   in_*  : stream of items. in_tuser = action (load / sample / query).
//           A load writes one CDF table entry.
//           A query reads entries i and i-1 and returns their difference (entry 0 alone for i = 0).
//           A sample scans the table from entry 0, one memory read per cycle,
//           stopping at the first entry above uniform_bucket, or after the n
//           entries in use (giving bucket 0) when none is above it. The single-port
//           table read sets this rate.
//   out_* : one beat per sample or query, out_tuser = result kind. Results sit
//           in an output register; a new item is taken while a result waits.
//           If the receiver stalls, the block holds the next finished result
//           until the output register frees.
//   cfg_* : APB-style register port, pready always high, words at 0, 4, 8.
//   Reset (rst_n low, synchronous) clears the FSM and the output valid flag and
//   sets the configuration registers to defaults. Table contents are undefined
//   until loaded and get no clearing pass.
module bucketed_inverse_cdf_sampler_unit
  import bics_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_index, entry_value, uniform_bucket, uniform_offset
  input  logic [1:0]             in_tuser,   // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // sample_value, bucket, probability
  output logic                   out_tuser,  // result_kind
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int MEM_DEPTH = (TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int CW = $clog2(MEM_DEPTH + 1);

  // configuration
  logic [SMP_W-1:0] range_min_r;
  logic [BW_W-1:0]  bucket_width_r;
  logic [BIU_W-1:0] buckets_in_use_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r      <= '0;
      bucket_width_r   <= BW_W'(65536);
      buckets_in_use_r <= BIU_W'(1024);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RANGE_MIN:      range_min_r      <= cfg_pwdata;
        REG_BUCKET_WIDTH:   bucket_width_r   <= cfg_pwdata[BW_W-1:0];
        REG_BUCKETS_IN_USE: buckets_in_use_r <= cfg_pwdata[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RANGE_MIN:      cfg_prdata = range_min_r;
      REG_BUCKET_WIDTH:   cfg_prdata = {1'b0, bucket_width_r};
      REG_BUCKETS_IN_USE: cfg_prdata = {21'd0, buckets_in_use_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // input fields
  logic [IDX_W-1:0] in_idx;
  logic [VAL_W-1:0] in_val;
  logic [UNI_W-1:0] in_ub;
  logic [UNI_W-1:0] in_uo;
  action_t          in_act;
  logic             in_acc;
  logic             idx_ok;
  logic [VAL_W-1:0] load_val;

  assign in_idx   = in_tdata[9:0];
  assign in_val   = in_tdata[42:10];
  assign in_ub    = in_tdata[74:43];
  assign in_uo    = in_tdata[106:75];
  assign in_act   = action_t'(in_tuser);
  assign in_acc   = in_tvalid && in_tready;
  assign idx_ok   = 32'(in_idx) < 32'(TABLE_DEPTH);
  assign load_val = (in_val > ONE_Q32) ? ONE_Q32 : in_val;

  // table memory
  logic [VAL_W-1:0] cdf_mem [MEM_DEPTH];
  logic [VAL_W-1:0] rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cdf_mem[in_idx[AW-1:0]] <= load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cdf_mem[rd_addr];
    end
  end

  // control
  state_t            state_r, state_nxt;
  logic [CW-1:0]     ra_r;
  logic [CW-1:0]     ck_r;
  logic              ckv_r;
  logic [CW-1:0]     n_r;
  logic [CW-1:0]     n_nxt;
  logic [UNI_W-1:0]  ub_r;
  logic [UNI_W-1:0]  uo_r;
  logic [IDX_W-1:0]  bucket_r;
  logic [IDX_W-1:0]  q_idx_r;
  logic [VAL_W-1:0]  cur_r;
  logic [VAL_W-1:0]  prob_r;
  result_kind_t      kind_r;
  logic [40:0]       prod_b_r;
  logic [30:0]       prod_o_r;
  logic [62:0]       prod_full;
  logic              hit;
  logic              scan_done;
  logic              out_free;
  logic              out_valid_r;

  assign hit       = ckv_r && ({1'b0, ub_r} < rd_data_r);
  assign scan_done = ckv_r && (hit || (ck_r == CW'(n_r - CW'(1))));
  assign out_free  = !out_valid_r || out_tready;
  assign prod_full = 63'(uo_r) * 63'(bucket_width_r);

  always_comb begin
    if (buckets_in_use_r == '0) begin
      n_nxt = CW'(1);
    end else if (buckets_in_use_r > BIU_W'(MEM_DEPTH)) begin
      n_nxt = CW'(MEM_DEPTH);
    end else begin
      n_nxt = CW'(buckets_in_use_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_act == ACT_SAMPLE) begin
            state_nxt = ST_SCAN;
          end else if (in_act == ACT_QUERY) begin
            state_nxt = idx_ok ? ST_QRD : ST_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: if (scan_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_QRD:  state_nxt = ST_QPRV;
      ST_QPRV: state_nxt = ST_QDIF;
      ST_QDIF: state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = ra_r[AW-1:0];
    wr_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        wr_en     = in_acc && (in_act == ACT_LOAD) && idx_ok;
      end
      ST_SCAN: begin
        rd_en   = ra_r < n_r;
        rd_addr = ra_r[AW-1:0];
      end
      ST_QRD: begin
        rd_en   = 1'b1;
        rd_addr = q_idx_r[AW-1:0];
      end
      ST_QPRV: begin
        rd_en   = q_idx_r != '0;
        rd_addr = q_idx_r[AW-1:0] - AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ckv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ckv_r   <= (state_r == ST_SCAN) && rd_en && !scan_done;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        ub_r    <= in_ub;
        uo_r    <= in_uo;
        n_r     <= n_nxt;
        ra_r    <= '0;
        q_idx_r <= in_idx;
        bucket_r <= in_idx;
        prob_r  <= '0;
        kind_r  <= (in_act == ACT_QUERY) ? KIND_QUERY : KIND_SAMPLE;
      end
      ST_SCAN: begin
        if (rd_en) ra_r <= ra_r + CW'(1);
        ck_r <= ra_r;
        if (scan_done) bucket_r <= hit ? IDX_W'(ck_r) : '0;
      end
      ST_MUL: begin
        prod_b_r <= 41'(bucket_r) * 41'(bucket_width_r);
        prod_o_r <= prod_full[62:32];
      end
      ST_QPRV: cur_r <= rd_data_r;
      ST_QDIF: begin
        if (q_idx_r == '0) begin
          prob_r <= cur_r;
        end else if (cur_r >= rd_data_r) begin
          prob_r <= cur_r - rd_data_r;
        end else begin
          prob_r <= '0;
        end
      end
      default: ;
    endcase
  end

  // scaling and saturation
  logic [42:0]      sum;
  logic [SMP_W-1:0] sat;

  assign sum = {{11{range_min_r[31]}}, range_min_r} + {2'b00, prod_b_r} + {12'd0, prod_o_r};

  always_comb begin
    if (sum[42:31] == '0 || sum[42:31] == '1) begin
      sat = sum[31:0];
    end else if (sum[42]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  // output register
  logic [SMP_W-1:0] o_smp_r;
  logic [IDX_W-1:0] o_bkt_r;
  logic [VAL_W-1:0] o_prob_r;
  result_kind_t     o_kind_r;
  logic             out_load;

  assign out_load = (state_r == ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind_r <= kind_r;
      o_bkt_r  <= bucket_r;
      o_smp_r  <= (kind_r == KIND_QUERY) ? '0 : sat;
      o_prob_r <= (kind_r == KIND_QUERY) ? prob_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tdata  = {5'd0, o_prob_r, o_bkt_r, o_smp_r};

endmodule
